### design/drq_pkg.sv
// ----------------------------------------------------------------------------
// drq_pkg
// Shared types and codes for the tag ring queue with duplicate filter.
// ----------------------------------------------------------------------------
package drq_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int MAX_TAG_BYTES_DEF = 8;

  // fixed field widths
  localparam int ACT_W    = 3;
  localparam int BYTES_W  = 64;
  localparam int LEN_W    = 4;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TAKE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ABORT    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FINALIZE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_DUP   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [BYTES_W-1:0] tag_bytes;
    logic [LEN_W-1:0]   tag_length;
    logic [STAMP_W-1:0] in_stamp;
  } in_item_t;

  typedef struct packed {
    logic [BYTES_W-1:0]  out_tag_bytes;
    logic [LEN_W-1:0]    out_tag_length;
    logic [STAMP_W-1:0]  out_stamp;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    fill_count;
    logic [CNT_W-1:0]    taken_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                load;
    logic                scan_start;
    logic                scan_step;
    logic                do_write;
    logic                take_rd;
    logic                abort;
    logic                finalize;
    logic                clear;
    logic                resp;
    logic                resp_rec;
    logic [STATUS_W-1:0] resp_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             none_left;
    logic             scan_hit;
    logic             scan_end;
  } sts_t;

endpackage

### design/drq_ctrl.sv
// ----------------------------------------------------------------------------
// drq_ctrl
// Sequencer: decodes the latched action, runs the duplicate scan and
// schedules the result transfer.
// ----------------------------------------------------------------------------
module drq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  drq_pkg::sts_t sts,
  output drq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP
  } state_t;

  state_t                        state_r, state_nxt;
  logic [drq_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic                          rec_r, rec_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    status_nxt = status_r;
    rec_nxt    = rec_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt  = S_RESP;
        status_nxt = drq_pkg::STS_DONE;
        rec_nxt    = 1'b0;
        unique case (sts.action)
          drq_pkg::ACT_INSERT: begin
            if (sts.full) begin
              status_nxt = drq_pkg::STS_FULL;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          drq_pkg::ACT_TAKE: begin
            if (sts.none_left) begin
              status_nxt = drq_pkg::STS_EMPTY;
            end else begin
              cmd.take_rd = 1'b1;
              rec_nxt     = 1'b1;
            end
          end
          drq_pkg::ACT_ABORT:    cmd.abort    = 1'b1;
          drq_pkg::ACT_FINALIZE: cmd.finalize = 1'b1;
          drq_pkg::ACT_CLEAR:    cmd.clear    = 1'b1;
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (sts.scan_hit) begin
          status_nxt = drq_pkg::STS_DUP;
          state_nxt  = S_RESP;
        end else if (sts.scan_end) begin
          cmd.do_write = 1'b1;
          status_nxt   = drq_pkg::STS_DONE;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_RESP: begin
        cmd.resp        = 1'b1;
        cmd.resp_rec    = rec_r;
        cmd.resp_status = status_r;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= drq_pkg::STS_DONE;
      rec_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      rec_r    <= rec_nxt;
    end
  end

endmodule

### design/drq_datapath.sv
// ----------------------------------------------------------------------------
// drq_datapath
// Record memory, ring indices, counters, scan compare and result register.
// ----------------------------------------------------------------------------
module drq_datapath #(
  parameter int QUEUE_DEPTH   = drq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TAG_BYTES = drq_pkg::MAX_TAG_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  drq_pkg::in_item_t  in_item,
  input  drq_pkg::cmd_t      cmd,
  output drq_pkg::sts_t      sts,
  output logic               out_valid,
  output drq_pkg::out_item_t out_item
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int BW = 8 * MAX_TAG_BYTES;
  localparam int RW = BW + drq_pkg::LEN_W + drq_pkg::STAMP_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [drq_pkg::LEN_W-1:0] MAX_LEN = drq_pkg::LEN_W'(MAX_TAG_BYTES);

  // ring add with one subtract for wrap
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(ofs);
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[AW-1:0];
  endfunction

  logic [RW-1:0] mem [QUEUE_DEPTH];

  logic [drq_pkg::ACT_W-1:0]   act_r;
  logic [BW-1:0]               key_bytes_r;
  logic [drq_pkg::LEN_W-1:0]   key_len_r;
  logic [drq_pkg::STAMP_W-1:0] stamp_r;

  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r, pend_r;
  logic [CW-1:0] scan_k_r;
  logic          cmp_v_r;
  logic [RW-1:0] rd_data_r;

  logic                      out_valid_r;
  drq_pkg::out_item_t        out_item_r;

  // input masking and length saturation
  logic [drq_pkg::LEN_W-1:0] sat_len;
  logic [BW-1:0]             masked_bytes;

  assign sat_len = (in_item.tag_length > MAX_LEN) ? MAX_LEN : in_item.tag_length;

  for (genvar i = 0; i < MAX_TAG_BYTES; i++) begin : g_mask
    assign masked_bytes[i*8 +: 8] =
      (drq_pkg::LEN_W'(i) < sat_len) ? in_item.tag_bytes[i*8 +: 8] : 8'h00;
  end

  // stored record fields
  logic [BW-1:0]               rd_bytes;
  logic [drq_pkg::LEN_W-1:0]   rd_len;
  logic [drq_pkg::STAMP_W-1:0] rd_stamp;
  logic [drq_pkg::BYTES_W-1:0] rd_bytes_ext;

  assign {rd_bytes, rd_len, rd_stamp} = rd_data_r;

  for (genvar i = 0; i < 8; i++) begin : g_ext
    if (i < MAX_TAG_BYTES) begin : g_on
      assign rd_bytes_ext[i*8 +: 8] = rd_bytes[i*8 +: 8];
    end else begin : g_off
      assign rd_bytes_ext[i*8 +: 8] = 8'h00;
    end
  end

  // read port
  logic          scan_issue;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  assign scan_issue = cmd.scan_step && (scan_k_r < count_r);
  assign rd_en      = cmd.take_rd || scan_issue;
  assign rd_addr    = cmd.take_rd ? ring_add(head_r, pend_r) : ring_add(head_r, scan_k_r);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.do_write) begin
      mem[tail_r] <= {key_bytes_r, key_len_r, stamp_r};
    end
  end

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r       <= in_item.action;
      key_bytes_r <= masked_bytes;
      key_len_r   <= sat_len;
      stamp_r     <= in_item.in_stamp;
    end
  end

  // ring bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      pend_r   <= '0;
      scan_k_r <= '0;
      cmp_v_r  <= 1'b0;
    end else begin
      priority if (cmd.clear) begin
        head_r  <= '0;
        tail_r  <= '0;
        count_r <= '0;
        pend_r  <= '0;
      end else if (cmd.finalize) begin
        head_r  <= ring_add(head_r, pend_r);
        count_r <= count_r - pend_r;
        pend_r  <= '0;
      end else if (cmd.abort) begin
        pend_r <= '0;
      end else if (cmd.take_rd) begin
        pend_r <= pend_r + 1'b1;
      end else if (cmd.do_write) begin
        tail_r  <= (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
        count_r <= count_r + 1'b1;
      end else begin
        pend_r <= pend_r;
      end
      if (cmd.scan_start) begin
        scan_k_r <= '0;
        cmp_v_r  <= 1'b0;
      end else if (cmd.scan_step) begin
        if (scan_issue) scan_k_r <= scan_k_r + 1'b1;
        cmp_v_r <= scan_issue;
      end
    end
  end

  // status to controller
  assign sts.action    = act_r;
  assign sts.full      = (count_r == DEPTH_C);
  assign sts.none_left = (pend_r >= count_r);
  assign sts.scan_hit  = cmp_v_r && (rd_len == key_len_r) && (rd_bytes == key_bytes_r);
  assign sts.scan_end  = !cmp_v_r && (scan_k_r >= count_r);

  // result register, counts widened then cut to the field width
  logic [CW+drq_pkg::CNT_W-1:0] count_ext, pend_ext;

  assign count_ext = {{drq_pkg::CNT_W{1'b0}}, count_r};
  assign pend_ext  = {{drq_pkg::CNT_W{1'b0}}, pend_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_item_r.out_tag_bytes  <= cmd.resp_rec ? rd_bytes_ext : '0;
      out_item_r.out_tag_length <= cmd.resp_rec ? rd_len : '0;
      out_item_r.out_stamp      <= cmd.resp_rec ? rd_stamp : '0;
      out_item_r.status         <= cmd.resp_status;
      out_item_r.fill_count     <= count_ext[drq_pkg::CNT_W-1:0];
      out_item_r.taken_count    <= pend_ext[drq_pkg::CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/dedup_ring_queue_with_pending_take_top.sv
// ----------------------------------------------------------------------------
// dedup_ring_queue_with_pending_take_top
// Ring queue of tag records with duplicate filter on insert and two-phase
// removal (take, abort, finalize), plus clear.
//
//   channel  ports                      transfer
//   -------  -------------------------  -------------------------------------
//   input    start, busy, in_item       start high while busy low
//   result   out_valid, out_item        out_valid high for one cycle
//
// one result per item; take, abort, finalize, clear, spare codes and inserts
// dropped as full pass through the execute and response states to the registered result strobe
// an insert reads the held entries one a cycle through the one memory port,
// stopping early on a duplicate hit
// busy stays high until the result is registered; the receiver cannot stall
// reset clears indices and counters; record memory content is not cleared
// ----------------------------------------------------------------------------
module dedup_ring_queue_with_pending_take_top #(
  parameter int QUEUE_DEPTH   = drq_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_TAG_BYTES = drq_pkg::MAX_TAG_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  drq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output drq_pkg::out_item_t out_item
);

  drq_pkg::cmd_t cmd;
  drq_pkg::sts_t sts;

  drq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  drq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MAX_TAG_BYTES (MAX_TAG_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
